/* hdl/tcct_pkg.sv */
// shared widths, constants and lane result type of the thermal charge current throttle
// no dependencies
package tcct_pkg;

   localparam int NUM_SENSORS = 4;
   localparam int NUM_LEVELS  = 4;

   localparam int TEMP_W      = 19;
   localparam int WGT_W       = 16;
   localparam int PROD_W      = TEMP_W + WGT_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int TOTAL_W     = WGT_W + 2;
   localparam int DIVIDEND_W  = SUM_W - 1;
   localparam int DIVISOR_W   = TOTAL_W;
   localparam int QUOT_W      = TEMP_W;
   localparam int DIV_STEPS   = DIVIDEND_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam int DECI_W      = 13;
   localparam int DECI_SHIFT  = 26;
   localparam int DECI_MULT_W = 20;
   localparam logic [DECI_MULT_W-1:0] DECI_RECIP = 20'd671089;

   localparam logic signed [TEMP_W-1:0] DEFAULT_TEMP = 19'sd25000;
   localparam logic signed [TEMP_W:0]   HYST_SHIFT   = 20'sd1000;

   localparam logic [2:0] REG_ENABLE     = 3'd0;
   localparam logic [2:0] REG_WEIGHTS    = 3'd1;
   localparam logic [2:0] REG_LEVEL_CNT  = 3'd2;
   localparam logic [2:0] REG_STABLE     = 3'd3;
   localparam logic [2:0] REG_THR_LOW    = 3'd4;
   localparam logic [2:0] REG_THR_HIGH   = 3'd5;
   localparam logic [2:0] REG_CUR_LOW    = 3'd6;
   localparam logic [2:0] REG_CUR_HIGH   = 3'd7;

   typedef struct packed {
      logic signed [PROD_W-1:0] prod;
      logic [WGT_W-1:0]         wgt;
   } lane_result_type;

endpackage

/* hdl/tcct_lane.sv */
// one sensor lane: gates a reading by its valid bit and weight, forms the weighted term
// depends on tcct_pkg
module tcct_lane (
   input  logic                             clock,
   input  logic                             load,
   input  logic                             valid,
   input  logic signed [tcct_pkg::TEMP_W-1:0] temp,
   input  logic [tcct_pkg::WGT_W-1:0]       weight,
   output tcct_pkg::lane_result_type        result
);
   import tcct_pkg::*;

   logic                      use_it;
   logic signed [PROD_W:0]    prod_full;
   lane_result_type           result_ff;

   assign use_it    = valid && (weight != '0);
   assign prod_full = temp * $signed({1'b0, weight});

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff.prod <= use_it ? prod_full[PROD_W-1:0] : '0;
         result_ff.wgt  <= use_it ? weight : '0;
      end
   end

   assign result = result_ff;

endmodule

/* hdl/tcct_div.sv */
// serial restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on tcct_pkg
module tcct_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tcct_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [tcct_pkg::DIVISOR_W-1:0]  divisor,
   output logic                            done,
   output logic [tcct_pkg::QUOT_W-1:0]     quotient
);
   import tcct_pkg::*;

   logic                   busy_ff;
   logic                   done_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [DIVISOR_W-1:0]   rem_ff;
   logic [DIVISOR_W-1:0]   div_ff;
   logic [DIVIDEND_W-1:0]  quo_ff;
   logic [DIVISOR_W:0]     trial;
   logic                   fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? DIVISOR_W'(trial - {1'b0, div_ff}) : trial[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[QUOT_W-1:0];

endmodule

/* hdl/thermal_charge_current_throttle_unit.sv */
// thermal charge current throttle: sensor lanes, merge, divide, level hysteresis
// depends on tcct_pkg, tcct_lane, tcct_div
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    req_tdata  (88 bits)
//   rsp      out  rsp_tvalid/tready    rsp_tdata  (72 bits)
//   csr      in   csr_wen              csr_addr, csr_wdata
//
// an evaluated item passes through the 36-step serial divider;
// an item with no valid weighted sensor skips the divider, and one that arrives
// disabled or not charging skips straight to the output stage. one item is in work at a time.
// reset is synchronous and clears control state and registers to their defaults.
// a result waits in the output register while rsp_tready is low; the next item
// is taken meanwhile and finishes once that register is free.
module thermal_charge_current_throttle_unit (
   input  logic        clock,
   input  logic        reset,
   // charging[0], sensor_valid[4:1], temp_zero[23:5], temp_one[42:24],
   // temp_two[61:43], temp_three[80:62], zero fill
   input  logic [87:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // active[0], update[1], level_out[3:2], current_limit[35:4],
   // skin_milli[54:36], skin_deci[67:55], zero fill
   output logic [71:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wen,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);
   import tcct_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_PREP,
      S_DIV,
      S_DECI,
      S_EVAL
   } state_type;

   state_type state_ff;

   logic        enable_ff;
   logic [63:0] weights_ff;
   logic [2:0]  level_count_ff;
   logic [7:0]  stable_ff;
   logic [63:0] thr_lo_ff;
   logic [63:0] thr_hi_ff;
   logic [63:0] cur_lo_ff;
   logic [63:0] cur_hi_ff;

   logic        held_valid_ff;
   logic [1:0]  held_level_ff;
   logic [7:0]  counter_ff;

   logic        bypass_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [TOTAL_W-1:0]       total_ff;
   logic signed [TEMP_W-1:0] skin_ff;
   logic [TEMP_W+DECI_MULT_W-1:0] deci_prod_ff;
   logic        deci_neg_ff;

   logic        rsp_valid_ff;
   logic [67:0] rsp_data_ff;

   logic        accept;
   logic        out_free;
   logic        rsp_valid_in;
   lane_result_type lane_res [NUM_SENSORS];

   logic signed [SUM_W-1:0] sum_in;
   logic [TOTAL_W-1:0]      total_in;
   logic [SUM_W-1:0]        sum_mag;
   logic                    div_start;
   logic                    div_done;
   logic [QUOT_W-1:0]       div_quot;
   logic [TEMP_W-1:0]       skin_mag;

   logic [2:0]  levels_n;
   logic signed [TEMP_W:0] skin_ext;
   logic signed [TEMP_W:0] skin_shift;
   logic [1:0]  target;
   logic [1:0]  step_to;
   logic        held_valid_in;
   logic [1:0]  held_level_in;
   logic [7:0]  counter_in;
   logic        update_in;
   logic [8:0]  count_base;
   logic [8:0]  count_next;
   logic [31:0] current_in;
   logic [DECI_W-1:0] deci_mag;
   logic signed [DECI_W-1:0] deci_in;
   logic [31:0] cur_tab [NUM_LEVELS];

   function automatic logic [1:0] range_index(
      input logic signed [TEMP_W:0] t,
      input logic [2:0]             n,
      input logic [63:0]            lo,
      input logic [63:0]            hi
   );
      logic signed [31:0] thr [NUM_LEVELS];
      logic [1:0]         idx;
      thr[0] = lo[31:0];
      thr[1] = lo[63:32];
      thr[2] = hi[31:0];
      thr[3] = hi[63:32];
      idx = 2'(n - 3'd1);
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if ((3'(i) < n) && (32'(t) < thr[i])) begin
            idx = 2'(i);
         end
      end
      return idx;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = ((state_ff == S_EVAL) && out_free) || (rsp_valid_ff && !rsp_tready);

   for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
      tcct_lane u_lane (
         .clock  (clock),
         .load   (accept),
         .valid  (req_tdata[1+g]),
         .temp   (req_tdata[5+TEMP_W*g +: TEMP_W]),
         .weight (weights_ff[WGT_W*g +: WGT_W]),
         .result (lane_res[g])
      );
   end

   always_comb begin
      sum_in   = '0;
      total_in = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         sum_in   = sum_in + SUM_W'(lane_res[i].prod);
         total_in = total_in + TOTAL_W'(lane_res[i].wgt);
      end
   end

   assign sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : sum_ff;
   assign div_start = (state_ff == S_PREP) && (total_ff != '0);

   tcct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag[DIVIDEND_W-1:0]),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign skin_mag = skin_ff[TEMP_W-1] ? TEMP_W'(-skin_ff) : skin_ff;
   assign deci_mag = deci_prod_ff[DECI_SHIFT +: DECI_W];
   assign deci_in  = deci_neg_ff ? DECI_W'(-deci_mag) : deci_mag;

   assign levels_n = (level_count_ff == 3'd0) ? 3'd1 :
                     (level_count_ff > 3'(NUM_LEVELS)) ? 3'(NUM_LEVELS) : level_count_ff;

   assign cur_tab[0] = cur_lo_ff[31:0];
   assign cur_tab[1] = cur_lo_ff[63:32];
   assign cur_tab[2] = cur_hi_ff[31:0];
   assign cur_tab[3] = cur_hi_ff[63:32];

   assign skin_ext   = {skin_ff[TEMP_W-1], skin_ff};
   assign target     = range_index(skin_ext, levels_n, thr_lo_ff, thr_hi_ff);
   assign skin_shift = skin_ext + ((held_level_ff < target) ? -HYST_SHIFT : HYST_SHIFT);
   assign step_to    = range_index(skin_shift, levels_n, thr_lo_ff, thr_hi_ff);
   assign count_base = (step_to == held_level_ff) ? 9'd0 : {1'b0, counter_ff};
   assign count_next = count_base + 9'd1;

   always_comb begin
      held_valid_in = 1'b1;
      held_level_in = held_level_ff;
      counter_in    = counter_ff;
      update_in     = 1'b0;
      if (!held_valid_ff) begin
         held_level_in = target;
         update_in     = 1'b1;
      end else if (held_level_ff != target) begin
         counter_in = count_next[7:0];
         if (count_next >= {1'b0, stable_ff}) begin
            counter_in = '0;
            if (held_level_ff < step_to) begin
               held_level_in = held_level_ff + 2'd1;
               update_in     = 1'b1;
            end else if (held_level_ff > step_to) begin
               held_level_in = held_level_ff - 2'd1;
               update_in     = 1'b1;
            end
         end
      end else begin
         counter_in = '0;
      end
   end

   assign current_in = cur_tab[held_level_in];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         weights_ff     <= '0;
         level_count_ff <= 3'd1;
         stable_ff      <= 8'd3;
         thr_lo_ff      <= '0;
         thr_hi_ff      <= '0;
         cur_lo_ff      <= '0;
         cur_hi_ff      <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_ENABLE:    enable_ff      <= csr_wdata[0];
            REG_WEIGHTS:   weights_ff     <= csr_wdata;
            REG_LEVEL_CNT: level_count_ff <= csr_wdata[2:0];
            REG_STABLE:    stable_ff      <= csr_wdata[7:0];
            REG_THR_LOW:   thr_lo_ff      <= csr_wdata;
            REG_THR_HIGH:  thr_hi_ff      <= csr_wdata;
            REG_CUR_LOW:   cur_lo_ff      <= csr_wdata;
            REG_CUR_HIGH:  cur_hi_ff      <= csr_wdata;
            default:       enable_ff      <= enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_valid_ff <= 1'b0;
         held_level_ff <= '0;
         counter_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         bypass_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  bypass_ff <= !enable_ff || !req_tdata[0];
                  state_ff  <= (!enable_ff || !req_tdata[0]) ? S_EVAL : S_SUM;
               end
            end
            S_SUM: begin
               sum_ff   <= sum_in;
               total_ff <= total_in;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               if (total_ff == '0) begin
                  skin_ff  <= DEFAULT_TEMP;
                  state_ff <= S_DECI;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  skin_ff  <= sum_ff[SUM_W-1] ? TEMP_W'(-div_quot) : div_quot;
                  state_ff <= S_DECI;
               end
            end
            S_DECI: begin
               deci_prod_ff <= skin_mag * DECI_RECIP;
               deci_neg_ff  <= skin_ff[TEMP_W-1];
               state_ff     <= S_EVAL;
            end
            S_EVAL: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
                  if (bypass_ff) begin
                     rsp_data_ff <= '0;
                     if (enable_ff) begin
                        held_valid_ff <= 1'b0;
                        held_level_ff <= '0;
                        counter_ff    <= '0;
                     end
                  end else begin
                     held_valid_ff <= held_valid_in;
                     held_level_ff <= held_level_in;
                     counter_ff    <= counter_in;
                     rsp_data_ff   <= {deci_in, skin_ff, current_in, held_level_in,
                                       update_in, 1'b1};
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};

endmodule
